// File: design/ac_zc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ac_zc_pkg
// Shared types and constants of the zero-crossing frequency and RMS meter.
// ---------------------------------------------------------------------------
package ac_zc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  // register map, word index
  localparam logic [2:0] REG_ZERO_OFFSET = 3'd0;
  localparam logic [2:0] REG_VOLTS_PER   = 3'd1;
  localparam logic [2:0] REG_BIAS        = 3'd2;
  localparam logic [2:0] REG_TICK_WRAP   = 3'd3;
  localparam logic [2:0] REG_TICK_RATE   = 3'd4;

  localparam logic [31:0] ZERO_OFFSET_RST = 32'd2150484306;
  localparam logic [31:0] VOLTS_PER_RST   = 32'd4434752;
  localparam logic [31:0] BIAS_RST        = 32'hFFFF_FC6F;  // -913
  localparam logic [16:0] TICK_WRAP_RST   = 17'd50000;
  localparam logic [19:0] TICK_RATE_RST   = 20'd50000;

  localparam int DIV_DW = 33;  // divisor / remainder width

  typedef struct packed {
    logic [31:0] zero_offset;
    logic [31:0] volts_per;
    logic [31:0] bias;
    logic [16:0] tick_wrap;
    logic [19:0] tick_rate;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_FRAC,
    DIV_FREQ,
    DIV_RMS
  } div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CONV1,
    S_CONV2,
    S_CONV3,
    S_CHECK,
    S_FRAC_LD,
    S_FRAC_RUN,
    S_PERIOD,
    S_FREQ_LD,
    S_FREQ_RUN,
    S_FREQ_TAKE,
    S_RMS_LD,
    S_RMS_RUN,
    S_SQRT_LD,
    S_SQRT_RUN,
    S_RMS_TAKE,
    S_EMIT,
    S_ACC
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     upd_peak;
    logic     div_start;
    div_sel_t div_sel;
    logic     per_load;
    logic     freq_sat;
    logic     freq_take;
    logic     rms_zero;
    logic     sqrt_start;
    logic     rms_take;
    logic     emit;
    logic     acc;
  } cmd_t;

  typedef struct packed {
    logic crossing;
    logic period_pos;
    logic count_nz;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } sts_t;

endpackage

// File: design/ac_zc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ac_zc_ctrl
// Sequencer: conversion, crossing math, divide/sqrt passes, emit, accumulate.
// ---------------------------------------------------------------------------
module ac_zc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ac_zc_pkg::sts_t   sts,
  output ac_zc_pkg::cmd_t   cmd
);
  import ac_zc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_FRAC;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CONV1;
        end
      end
      S_CONV1: state_next = S_CONV2;
      S_CONV2: state_next = S_CONV3;
      S_CONV3: state_next = S_CHECK;
      S_CHECK: begin
        cmd.upd_peak = 1'b1;
        state_next   = sts.crossing ? S_FRAC_LD : S_ACC;
      end
      S_FRAC_LD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FRAC;
        state_next    = S_FRAC_RUN;
      end
      S_FRAC_RUN: begin
        if (!sts.div_busy) state_next = S_PERIOD;
      end
      S_PERIOD: begin
        cmd.per_load = 1'b1;
        state_next   = S_FREQ_LD;
      end
      S_FREQ_LD: begin
        if (sts.period_pos) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_FREQ;
          state_next    = S_FREQ_RUN;
        end else begin
          cmd.freq_sat = 1'b1;
          state_next   = S_RMS_LD;
        end
      end
      S_FREQ_RUN: begin
        if (!sts.div_busy) state_next = S_FREQ_TAKE;
      end
      S_FREQ_TAKE: begin
        cmd.freq_take = 1'b1;
        state_next    = S_RMS_LD;
      end
      S_RMS_LD: begin
        if (sts.count_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RMS;
          state_next    = S_RMS_RUN;
        end else begin
          cmd.rms_zero = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_RMS_RUN: begin
        if (!sts.div_busy) state_next = S_SQRT_LD;
      end
      S_SQRT_LD: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT_RUN;
      end
      S_SQRT_RUN: begin
        if (!sts.sqrt_busy) state_next = S_RMS_TAKE;
      end
      S_RMS_TAKE: begin
        cmd.rms_take = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: design/ac_zc_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ac_zc_dp
// Datapath: voltage conversion, window state, shared divider, square root,
// output register.
// ---------------------------------------------------------------------------
module ac_zc_dp #(
  parameter int COUNT_WIDTH = ac_zc_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ac_zc_pkg::cfg_t   cfg,
  input  ac_zc_pkg::cmd_t   cmd,
  output ac_zc_pkg::sts_t   sts,
  input  logic [15:0]       sample_tick,
  input  logic [15:0]       adc_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       crossing_tick,
  output logic [31:0]       frequency_hz,
  output logic [30:0]       rms_volts,
  output logic [31:0]       peak_high_volts,
  output logic [31:0]       peak_low_volts,
  output logic              frequency_saturated
);
  import ac_zc_pkg::*;

  // input beat
  logic [15:0] in_tick;
  logic [15:0] in_adc;

  // conversion pipe (free running off the held input)
  logic signed [32:0] diff;
  logic               c1_neg;
  logic [32:0]        c1_mag;
  logic               c2_neg;
  logic [48:0]        c2_p;
  logic [48:0]        c2_q;
  logic [49:0]        magsum;
  logic [33:0]        mag;
  logic signed [35:0] sval;
  logic [31:0]        volt;
  logic [31:0]        abs_v;
  logic [63:0]        sq;

  // window / crossing state
  logic                   was_pos;
  logic [31:0]            prev_v;
  logic [15:0]            tick_prev;
  logic [15:0]            frac_prev;
  logic [31:0]            win_hi;
  logic [31:0]            win_lo;
  logic [63:0]            sum;
  logic [COUNT_WIDTH-1:0] count;

  // crossing working terms and registers
  logic [31:0]        num;
  logic [32:0]        den;
  logic signed [18:0] dur;
  logic signed [35:0] period_c;
  logic signed [35:0] period;
  logic [15:0]        frac;
  logic [31:0]        freq_r;
  logic               sat_r;
  logic [30:0]        rms_r;

  // divider
  logic [63:0]       div_q;
  logic [DIV_DW-1:0] div_r;
  logic [DIV_DW-1:0] div_d;
  logic [5:0]        div_cnt;
  logic              div_busy;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   trial_sub;

  // square root
  logic [63:0] sq_x;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [63:0] sq_t;

  logic [64:0] sum_add;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_tick <= sample_tick;
      in_adc  <= adc_sample;
    end
  end

  // stage 1: signed distance from the zero code, as sign and magnitude
  assign diff = $signed({1'b0, in_adc, 16'b0}) - $signed({1'b0, cfg.zero_offset});

  always_ff @(posedge clk) begin
    c1_neg <= diff[32];
    c1_mag <= diff[32] ? 33'(-diff) : 33'(diff);
  end

  // stage 2: split gain multiply
  always_ff @(posedge clk) begin
    c2_neg <= c1_neg;
    c2_p   <= c1_mag * cfg.volts_per[31:16];
    c2_q   <= c1_mag * cfg.volts_per[15:0];
  end

  // stage 3: round, sign, bias, clamp
  assign magsum = {1'b0, c2_p} + 50'd32768 + {17'b0, c2_q[48:16]};
  assign mag    = magsum[49:16];
  assign sval   = (c2_neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag}))
                + $signed({{4{cfg.bias[31]}}, cfg.bias});

  always_ff @(posedge clk) begin
    if (sval[35:31] == 5'b00000 || sval[35:31] == 5'b11111) begin
      volt <= sval[31:0];
    end else if (sval[35]) begin
      volt <= 32'h8000_0000;
    end else begin
      volt <= 32'h7FFF_FFFF;
    end
  end

  assign abs_v = volt[31] ? 32'(-volt) : volt;

  always_ff @(posedge clk) begin
    sq <= abs_v * abs_v;
  end

  // crossing terms
  assign num = prev_v[31] ? 32'(-prev_v) : prev_v;
  assign den = {1'b0, volt} + {1'b0, num};

  assign dur = (in_tick < tick_prev)
             ? $signed({2'b0, cfg.tick_wrap}) - $signed({3'b0, tick_prev})
               + $signed({3'b0, in_tick})
             : $signed({3'b0, in_tick}) - $signed({3'b0, tick_prev});

  assign period_c = $signed({dur[18], dur, 16'b0}) + $signed({20'b0, div_q[15:0]})
                  - $signed({20'b0, frac_prev});

  always_ff @(posedge clk) begin
    if (cmd.per_load) begin
      frac   <= div_q[15:0];
      period <= period_c;
    end
    if (cmd.freq_sat) begin
      freq_r <= 32'hFFFF_FFFF;
      sat_r  <= 1'b1;
    end else if (cmd.freq_take) begin
      freq_r <= (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
      sat_r  <= 1'b0;
    end
    if (cmd.rms_zero) begin
      rms_r <= 31'd0;
    end else if (cmd.rms_take) begin
      rms_r <= (sq_res > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sq_res[30:0];
    end
  end

  // restoring divider, one quotient bit per cycle; dividend left-aligned,
  // quotient collects in the low bits
  assign trial     = {div_r, div_q[63]};
  assign trial_sub = trial - {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == 6'd0) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_r <= '0;
      case (cmd.div_sel)
        DIV_FRAC: begin
          div_q   <= {num, 32'b0};
          div_d   <= den;
          div_cnt <= 6'd47;
        end
        DIV_FREQ: begin
          div_q   <= {cfg.tick_rate, 44'b0};
          div_d   <= period[DIV_DW-1:0];
          div_cnt <= 6'd51;
        end
        default: begin
          div_q   <= sum;
          div_d   <= DIV_DW'(count);
          div_cnt <= 6'd63;
        end
      endcase
    end else if (div_busy) begin
      if (!trial_sub[DIV_DW]) begin
        div_r <= trial_sub[DIV_DW-1:0];
        div_q <= {div_q[62:0], 1'b1};
      end else begin
        div_r <= trial[DIV_DW-1:0];
        div_q <= {div_q[62:0], 1'b0};
      end
      div_cnt <= div_cnt - 6'd1;
    end
  end

  // bitwise integer square root, one result bit per cycle
  assign sq_t = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_bit <= '0;
    end else if (cmd.sqrt_start) begin
      sq_bit <= 64'h4000_0000_0000_0000;
    end else if (sq_bit != 64'd0) begin
      sq_bit <= sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_x   <= div_q;
      sq_res <= '0;
    end else if (sq_bit != 64'd0) begin
      if (sq_x >= sq_t) begin
        sq_x   <= sq_x - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
    end
  end

  // window state
  assign sum_add = {1'b0, sum} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pos   <= 1'b0;
      prev_v    <= '0;
      tick_prev <= '0;
      frac_prev <= '0;
      win_hi    <= '0;
      win_lo    <= '0;
      sum       <= '0;
      count     <= '0;
    end else begin
      if (cmd.upd_peak) begin
        if ($signed(volt) > $signed(win_hi)) win_hi <= volt;
        if ($signed(volt) < $signed(win_lo)) win_lo <= volt;
      end
      if (cmd.emit) begin
        tick_prev <= in_tick;
        frac_prev <= frac;
        win_hi    <= '0;
        win_lo    <= '0;
        sum       <= '0;
        count     <= '0;
      end
      if (cmd.acc) begin
        sum     <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
        if (count != {COUNT_WIDTH{1'b1}}) count <= count + 1'b1;
        was_pos <= !volt[31] && (volt != 32'd0);
        prev_v  <= volt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      crossing_tick       <= in_tick;
      frequency_hz        <= freq_r;
      rms_volts           <= rms_r;
      peak_high_volts     <= win_hi;
      peak_low_volts      <= win_lo;
      frequency_saturated <= sat_r;
    end
  end

  assign sts.crossing   = !volt[31] && (volt != 32'd0) && !was_pos;
  assign sts.period_pos = !period[35] && (period != 36'sd0);
  assign sts.count_nz   = (count != '0);
  assign sts.div_busy   = div_busy;
  assign sts.sqrt_busy  = (sq_bit != 64'd0);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// File: design/ac_zero_cross_frequency_rms_meter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ac_zero_cross_frequency_rms_meter
// AC line meter: frequency from rising zero crossings, windowed RMS and peaks.
// ---------------------------------------------------------------------------
// Each input beat is one timestamped ADC sample. The sample is turned into a
// signed Q16.16 voltage (offset, gain, bias, clamped), the window peaks and
// the sum of squares are updated, and on every rising zero crossing one
// output beat carries the crossing tick, the frequency in Q16.16 Hz, the RMS
// of the window, both peaks, and a flag for a period that came out zero or
// negative; the window then restarts. Items are handled one at a time. A
// sample with no crossing passes the 3-stage conversion and the window
// update before the next accept. For a crossing sample the single shared
// restoring divider, one quotient bit per cycle, runs the crossing
// fraction, the frequency and, for a non-empty window, the mean square,
// followed by a bitwise square root, each pass with its sequencing states.
// An empty window skips the mean square and root; a period that is not
// positive skips the frequency pass. The result sits in an output register,
// so the next sample is taken while the result waits; only a second
// crossing waits for the first result to leave. Registers sit on an APB
// port at byte offsets 0, 4, 8, 12, 16 (zero offset, gain, bias, tick
// wrap, tick rate) and are to be written while the meter is idle.
// ---------------------------------------------------------------------------
module ac_zero_cross_frequency_rms_meter #(
  parameter int COUNT_WIDTH = ac_zc_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // sample stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [15:0] sample_tick, [31:16] adc_sample
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] crossing_tick, [47:16] frequency_hz, [78:48] rms_volts,
  // [110:79] peak_high_volts, [142:111] peak_low_volts, [143] zero pad
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tuser,   // [0] frequency_saturated
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ac_zc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic        wr_en;
  logic [2:0]  reg_idx;
  logic [15:0] o_tick;
  logic [31:0] o_freq;
  logic [30:0] o_rms;
  logic [31:0] o_hi;
  logic [31:0] o_lo;
  logic        o_sat;

  // register file: write on the access phase, zero-wait
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_offset <= ZERO_OFFSET_RST;
      cfg.volts_per   <= VOLTS_PER_RST;
      cfg.bias        <= BIAS_RST;
      cfg.tick_wrap   <= TICK_WRAP_RST;
      cfg.tick_rate   <= TICK_RATE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ZERO_OFFSET: cfg.zero_offset <= pwdata;
        REG_VOLTS_PER:   cfg.volts_per   <= pwdata;
        REG_BIAS:        cfg.bias        <= pwdata;
        REG_TICK_WRAP:   cfg.tick_wrap   <= pwdata[16:0];
        REG_TICK_RATE:   cfg.tick_rate   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ZERO_OFFSET: prdata = cfg.zero_offset;
      REG_VOLTS_PER:   prdata = cfg.volts_per;
      REG_BIAS:        prdata = cfg.bias;
      REG_TICK_WRAP:   prdata = {15'b0, cfg.tick_wrap};
      REG_TICK_RATE:   prdata = {12'b0, cfg.tick_rate};
      default:         prdata = 32'd0;
    endcase
  end

  ac_zc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ac_zc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .sts                 (sts),
    .sample_tick         (s_axis_tdata[15:0]),
    .adc_sample          (s_axis_tdata[31:16]),
    .out_valid           (m_axis_tvalid),
    .out_ready           (m_axis_tready),
    .crossing_tick       (o_tick),
    .frequency_hz        (o_freq),
    .rms_volts           (o_rms),
    .peak_high_volts     (o_hi),
    .peak_low_volts      (o_lo),
    .frequency_saturated (o_sat)
  );

  assign m_axis_tdata = {1'b0, o_lo, o_hi, o_rms, o_freq, o_tick};
  assign m_axis_tuser = o_sat;

endmodule
